FILE: design/pbst_pkg.sv
// Package for the peer ban score table: sizes, codes, the chain word and the
// write command. Used by pbst_cell and peer_ban_score_table.
package pbst_pkg;

    localparam int DEPTH = 256;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DLW   = 48;
    localparam logic [DLW-1:0] DEADLINE_MAX = {DLW{1'b1}};

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CHECK  = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SCORE_LIMIT = 2'd0,
        CFG_EXCLUDE     = 2'd1,
        CFG_REMOVE      = 2'd2,
        CFG_FRACTION    = 2'd3
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_SCAN,
        ST_CALC,
        ST_FINISH
    } t_state;

    // word handed from cell to cell during a scan
    typedef struct packed {
        logic           match_hit;
        logic [IW-1:0]  match_idx;
        logic [7:0]     match_score;
        logic [DLW-1:0] match_deadline;
        logic           free_hit;
        logic [IW-1:0]  free_idx;
        logic           best_hit;
        logic [IW-1:0]  best_idx;
        logic [DLW-1:0] best_deadline;
    } t_carry;

    // broadcast key and entry write
    typedef struct packed {
        logic [63:0]    key_high;
        logic [63:0]    key_low;
        logic           wr_en;
        logic [IW-1:0]  wr_idx;
        logic           wr_valid;
        logic [7:0]     wr_score;
        logic [DLW-1:0] wr_deadline;
    } t_cmd;

    // clamp a deadline sum to the 48-bit maximum
    function automatic logic [DLW-1:0] sat_deadline(input logic [DLW:0] sum);
        logic [DLW-1:0] res;
        res = sum[DLW] ? DEADLINE_MAX : sum[DLW-1:0];
        return res;
    endfunction

endpackage

FILE: design/pbst_cell.sv
// One table entry of the peer ban score table and its stage of the scan chain.
// Depends on pbst_pkg.
module pbst_cell import pbst_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_index,
    input  t_cmd          i_cmd,
    input  t_carry        i_carry,
    output t_carry        o_carry
);

    logic           r_valid;
    logic [63:0]    r_key_high;
    logic [63:0]    r_key_low;
    logic [7:0]     r_score;
    logic [DLW-1:0] r_deadline;
    t_carry         r_carry;
    t_carry         n_carry;
    logic           hit;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr_en && i_cmd.wr_idx == i_index) begin
            r_valid <= i_cmd.wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && i_cmd.wr_idx == i_index) begin
            r_key_high <= i_cmd.key_high;
            r_key_low  <= i_cmd.key_low;
            r_score    <= i_cmd.wr_score;
            r_deadline <= i_cmd.wr_deadline;
        end
    end

    assign hit = r_valid && r_key_high == i_cmd.key_high && r_key_low == i_cmd.key_low;

    // merge this entry into the word; lower cells already had first claim
    always_comb begin
        n_carry = i_carry;
        if (hit && !i_carry.match_hit) begin
            n_carry.match_hit      = 1'b1;
            n_carry.match_idx      = i_index;
            n_carry.match_score    = r_score;
            n_carry.match_deadline = r_deadline;
        end
        if (!r_valid && !i_carry.free_hit) begin
            n_carry.free_hit = 1'b1;
            n_carry.free_idx = i_index;
        end
        if (r_valid && (!i_carry.best_hit || r_deadline < i_carry.best_deadline)) begin
            n_carry.best_hit      = 1'b1;
            n_carry.best_idx      = i_index;
            n_carry.best_deadline = r_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

FILE: design/peer_ban_score_table.sv
// Top level of the peer ban score table: configuration, control sequencer and
// the chain of pbst_cell entries. Depends on pbst_pkg and pbst_cell.

// Peer ban score table. Each input word (tuser = kind; tdata = addr_high,
// addr_low, now_time, peer_count) gives exactly one result word (score_out,
// excluded, entry_count). The table is a chain of DEPTH cells. Every operation
// first works out the limit in ST_LIMIT, then makes one pass while the search
// word walks the chain, and then finishes in ST_CALC and ST_FINISH. An add
// that evicts E entries makes E extra passes. One item is worked on at a time;
// a new word is taken while the previous result waits on the output, and the
// item after that stalls until the output register is free.
module peer_ban_score_table import pbst_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [19:0]  i_cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [183:0] s_tdata,   // addr_high[63:0], addr_low[127:64],
                                    // now_time[167:128], peer_count[183:168]
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata    // score_out[7:0], excluded[8],
                                    // entry_count[17:9], zero fill
);

    logic [7:0]  r_score_limit;
    logic [19:0] r_exclude;
    logic [19:0] r_remove;
    logic [8:0]  r_fraction;

    t_state         r_state, n_state;
    t_kind          r_kind;
    logic [63:0]    r_key_high, r_key_low;
    logic [39:0]    r_now;
    logic [15:0]    r_peers;
    logic [CW-1:0]  r_limit, n_limit;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_cnt, n_cnt;
    t_carry         r_res;
    logic [7:0]     r_nscore;
    logic [27:0]    r_pa, r_pr;
    logic           r_out_valid;
    logic [7:0]     r_out_score;
    logic           r_out_excl;
    logic [8:0]     r_out_count;

    t_cmd           cmd;
    t_carry         chain [DEPTH+1];
    logic [24:0]    lim_prod;
    logic [16:0]    lim_shift;
    logic [7:0]     nscore;
    logic           out_free;
    logic           evict;
    logic           load_out;
    logic [7:0]     n_out_score;
    logic           n_out_excl;
    logic [DLW:0]   chk_sum;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_limit <= 8'd2;
            r_exclude     <= 20'd3600;
            r_remove      <= 20'd86400;
            r_fraction    <= 9'd128;
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_addr))
                CFG_SCORE_LIMIT: r_score_limit <= i_cfg_wdata[7:0];
                CFG_EXCLUDE:     r_exclude     <= i_cfg_wdata;
                CFG_REMOVE:      r_remove      <= i_cfg_wdata;
                CFG_FRACTION:    r_fraction    <= i_cfg_wdata[8:0];
                default:         ;
            endcase
        end
    end

    // chain of entries
    assign chain[0] = '0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pbst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IW'(g)),
            .i_cmd   (cmd),
            .i_carry (chain[g]),
            .o_carry (chain[g+1])
        );
    end

    assign s_tready  = (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || m_tready;
    assign lim_prod  = r_peers * r_fraction;
    assign lim_shift = lim_prod[24:8];
    assign nscore    = (r_res.match_score == 8'hFF) ? 8'hFF : r_res.match_score + 8'd1;
    assign evict     = (r_kind == KIND_ADD) && r_count > CW'(1) && r_count > r_limit;
    assign chk_sum   = {1'b0, r_res.match_deadline} + (DLW+1)'(r_pr);

    // sequencer: next state, entry writes and result
    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_count     = r_count;
        n_cnt       = r_cnt;
        load_out    = 1'b0;
        n_out_score = 8'd0;
        n_out_excl  = 1'b0;
        cmd             = '0;
        cmd.key_high    = r_key_high;
        cmd.key_low     = r_key_low;
        cmd.wr_idx      = r_res.match_idx;
        cmd.wr_score    = r_res.match_score;
        cmd.wr_deadline = r_res.match_deadline;
        case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                n_limit = (lim_shift > 17'(DEPTH - 1)) ? CW'(DEPTH - 1) : lim_shift[CW-1:0];
                n_cnt   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DEPTH)) begin
                    n_cnt = '0;
                    if (evict) begin
                        // drop the entry with the earliest deadline and rescan
                        cmd.wr_en    = 1'b1;
                        cmd.wr_idx   = chain[DEPTH].best_idx;
                        cmd.wr_valid = 1'b0;
                        n_count      = r_count - CW'(1);
                    end else begin
                        n_state = ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    case (r_kind)
                        KIND_ADD: begin
                            if (r_res.match_hit) begin
                                cmd.wr_en    = 1'b1;
                                cmd.wr_valid = 1'b1;
                                cmd.wr_score = r_nscore;
                                if (r_nscore == r_score_limit) begin
                                    cmd.wr_deadline = sat_deadline(
                                        (DLW+1)'(r_now) + (DLW+1)'(r_exclude));
                                end else if (r_nscore > r_score_limit) begin
                                    cmd.wr_deadline = sat_deadline(
                                        (DLW+1)'(r_now) + ((DLW+1)'(r_pa) << 1));
                                end
                                n_out_score = r_nscore;
                            end else if (r_res.free_hit) begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_idx      = r_res.free_idx;
                                cmd.wr_valid    = 1'b1;
                                cmd.wr_score    = 8'd1;
                                cmd.wr_deadline = sat_deadline(
                                    (DLW+1)'(r_now) + (DLW+1)'(r_exclude));
                                n_count         = r_count + CW'(1);
                                n_out_score     = 8'd1;
                            end
                        end
                        KIND_CHECK: begin
                            if (r_res.match_hit && r_res.match_score >= r_score_limit) begin
                                if (r_res.match_deadline > DLW'(r_now)) begin
                                    n_out_excl = 1'b1;
                                end else if (chk_sum < (DLW+1)'(r_now)) begin
                                    cmd.wr_en    = 1'b1;
                                    cmd.wr_valid = 1'b0;
                                    n_count      = r_count - CW'(1);
                                end
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_res.match_hit) begin
                                cmd.wr_en    = 1'b1;
                                cmd.wr_valid = 1'b0;
                                n_count      = r_count - CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cnt   <= n_cnt;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and work registers
    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        if (r_state == ST_IDLE && s_tvalid) begin
            r_kind     <= t_kind'(s_tuser);
            r_key_high <= s_tdata[63:0];
            r_key_low  <= s_tdata[127:64];
            r_now      <= s_tdata[167:128];
            r_peers    <= s_tdata[183:168];
        end
        if (r_state == ST_SCAN && r_cnt == CW'(DEPTH)) begin
            r_res <= chain[DEPTH];
        end
        if (r_state == ST_CALC) begin
            r_nscore <= nscore;
            r_pa     <= r_exclude * nscore;
            r_pr     <= r_remove * r_res.match_score;
        end
        if (load_out) begin
            r_out_score <= n_out_score;
            r_out_excl  <= n_out_excl;
            r_out_count <= 9'(n_count);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out_count, r_out_excl, r_out_score};

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_cnt <= CW'(DEPTH))
        else $error("scan counter overran the chain");
    a_finish_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH && out_free |=> m_tvalid && r_state == ST_IDLE)
        else $error("result not loaded on finish");
    a_evict_add_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN && cmd.wr_en |-> r_kind == KIND_ADD && !cmd.wr_valid)
        else $error("eviction write outside add");

endmodule

FILE: dv/peer_ban_checker.sv
// Checker for the peer ban score table: watches the register port and both
// streams, keeps its own copy of the table and compares every result word.
// Depends on pbst_pkg.
`timescale 1ns / 1ps

module peer_ban_checker import pbst_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [19:0]  i_cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [183:0] s_tdata,   // addr_high[63:0], addr_low[127:64],
                                    // now_time[167:128], peer_count[183:168]
    input  logic [1:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,   // score_out[7:0], excluded[8],
                                    // entry_count[17:9], zero fill
    output int           o_err_count,
    output int           o_pending
);

    typedef struct {
        logic [7:0] score;
        logic       excl;
        logic [8:0] count;
    } t_verdict;

    // shadow table
    logic           tbl_valid [DEPTH];
    logic [63:0]    tbl_high  [DEPTH];
    logic [63:0]    tbl_low   [DEPTH];
    logic [7:0]     tbl_score [DEPTH];
    logic [DLW-1:0] tbl_dl    [DEPTH];
    int             tbl_count;

    // shadow registers
    logic [7:0]  lim_score;
    logic [19:0] excl_secs;
    logic [19:0] rem_secs;
    logic [8:0]  frac;

    t_verdict verdicts_due[$];
    int       errs;

    function automatic int find_slot(logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_high[i] == hi && tbl_low[i] == lo) return i;
        return -1;
    endfunction

    function automatic logic [DLW-1:0] deadline_after(logic [39:0] now, logic [63:0] span);
        logic [63:0] sum;
        sum = {24'd0, now} + span;
        return (sum > {16'd0, DEADLINE_MAX}) ? DEADLINE_MAX : sum[DLW-1:0];
    endfunction

    function automatic void drop_slot(int s);
        if (tbl_valid[s]) begin
            tbl_valid[s] = 1'b0;
            if (tbl_count > 0) tbl_count--;
        end
    endfunction

    // apply one word to the shadow table and return the result it must give
    function automatic t_verdict score_table_step(t_kind kind, logic [63:0] hi,
                                                  logic [63:0] lo, logic [39:0] now,
                                                  logic [15:0] peers);
        t_verdict    v;
        logic [63:0] cap;
        int          s;
        int          best;
        v.score = 8'd0;
        v.excl  = 1'b0;
        case (kind)
            KIND_ADD: begin
                cap = (64'(peers) * 64'(frac)) >> 8;
                if (cap > DEPTH - 1) cap = DEPTH - 1;
                // evict earliest deadlines, lowest slot on ties
                while (tbl_count > 1 && 64'(tbl_count) > cap) begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (tbl_valid[i] && (best < 0 || tbl_dl[i] < tbl_dl[best])) best = i;
                    drop_slot(best);
                end
                s = find_slot(hi, lo);
                if (s < 0) begin
                    for (int i = 0; i < DEPTH; i++)
                        if (!tbl_valid[i]) begin
                            s = i;
                            break;
                        end
                    if (s >= 0) begin
                        tbl_valid[s] = 1'b1;
                        tbl_high[s]  = hi;
                        tbl_low[s]   = lo;
                        tbl_score[s] = 8'd1;
                        tbl_dl[s]    = deadline_after(now, 64'(excl_secs));
                        tbl_count++;
                        v.score = 8'd1;
                    end
                end else begin
                    if (tbl_score[s] != 8'hFF) tbl_score[s]++;
                    if (tbl_score[s] == lim_score)
                        tbl_dl[s] = deadline_after(now, 64'(excl_secs));
                    else if (tbl_score[s] > lim_score)
                        tbl_dl[s] = deadline_after(now,
                                        64'(excl_secs) * 64'(tbl_score[s]) * 64'd2);
                    v.score = tbl_score[s];
                end
            end
            KIND_CHECK: begin
                s = find_slot(hi, lo);
                if (s >= 0 && tbl_score[s] >= lim_score) begin
                    if (tbl_dl[s] > 48'(now))
                        v.excl = 1'b1;
                    else if (64'(tbl_dl[s]) + 64'(rem_secs) * 64'(tbl_score[s]) < 64'(now))
                        drop_slot(s);
                end
            end
            KIND_REMOVE: begin
                s = find_slot(hi, lo);
                if (s >= 0) drop_slot(s);
            end
            default: ;
        endcase
        v.count = tbl_count[8:0];
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
            tbl_count = 0;
            lim_score = 8'd2;
            excl_secs = 20'd3600;
            rem_secs  = 20'd86400;
            frac      = 9'd128;
            verdicts_due.delete();
            errs = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg'(i_cfg_addr))
                    CFG_SCORE_LIMIT: lim_score = i_cfg_wdata[7:0];
                    CFG_EXCLUDE:     excl_secs = i_cfg_wdata;
                    CFG_REMOVE:      rem_secs  = i_cfg_wdata;
                    CFG_FRACTION:    frac      = i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                verdicts_due.push_back(score_table_step(t_kind'(s_tuser), s_tdata[63:0],
                                       s_tdata[127:64], s_tdata[167:128], s_tdata[183:168]));
            if (m_tvalid && m_tready) begin
                got.score = m_tdata[7:0];
                got.excl  = m_tdata[8];
                got.count = m_tdata[17:9];
                if (verdicts_due.size() == 0) begin
                    if (errs < 10)
                        $display("%0t: unexpected result word score=%0d excl=%0d count=%0d",
                                 $realtime, got.score, got.excl, got.count);
                    errs++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.score !== want.score || got.excl !== want.excl ||
                        got.count !== want.count) begin
                        if (errs < 10)
                            $display("%0t: mismatch score %0d/%0d excl %0d/%0d count %0d/%0d (exp/act)",
                                     $realtime, want.score, got.score, want.excl, got.excl,
                                     want.count, got.count);
                        errs++;
                    end
                end
            end
        end
        o_err_count <= errs;
        o_pending   <= verdicts_due.size();
    end

endmodule

FILE: dv/tb_peer_ban_score_table.sv
// Top of the peer ban score table testbench: clock, reset, register writes,
// bursty stimulus, receiver stalls and the verdict. Depends on pbst_pkg,
// peer_ban_score_table and peer_ban_checker.
`timescale 1ns / 1ps

module tb_peer_ban_score_table;
    import pbst_pkg::*;

    localparam int IDLE_LIMIT  = 300000;
    localparam int HOLD_START  = 60000;
    localparam int HOLD_CYCLES = 4000;
    localparam int POOL_SIZE   = 16;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [19:0]  i_cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    int           err_count;
    int           pending;

    logic [63:0] pool_high [POOL_SIZE];
    logic [63:0] pool_low  [POOL_SIZE];
    logic [39:0] clock_secs;
    int          burst_left;
    int          idle_cycles;
    int          rx_cycle;
    int          rx_mode;

    peer_ban_score_table dut (.*);

    peer_ban_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .o_err_count(err_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: randomly chosen stall pattern, one long hold-off
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 32 == 0) rx_mode <= $urandom_range(0, 3);
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            m_tready <= 1'b0;
        else
            case (rx_mode)
                0, 1:    m_tready <= 1'b1;
                2:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
    end
    initial rx_cycle = 0;
    initial rx_mode = 0;

    // watchdog on cycles with no word moving
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_regs(logic [7:0] lim, logic [19:0] excl, logic [19:0] rem,
                              logic [8:0] frac);
        i_cfg_we <= 1'b1; i_cfg_addr <= CFG_SCORE_LIMIT; i_cfg_wdata <= 20'(lim);
        @(posedge i_clk);
        i_cfg_addr <= CFG_EXCLUDE; i_cfg_wdata <= excl;
        @(posedge i_clk);
        i_cfg_addr <= CFG_REMOVE; i_cfg_wdata <= rem;
        @(posedge i_clk);
        i_cfg_addr <= CFG_FRACTION; i_cfg_wdata <= 20'(frac);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one word, with random gaps between bursts
    task automatic send_word(t_kind kind, logic [63:0] hi, logic [63:0] lo,
                             logic [39:0] now, logic [15:0] peers);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {peers, now, lo, hi};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // stop offering and wait until every result word is back
    task automatic drain;
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_words(int count);
        t_kind       kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [39:0] now;
        logic [15:0] peers;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 50) ? KIND_ADD : (pick < 85) ? KIND_CHECK :
                   (pick < 95) ? KIND_REMOVE : KIND_NONE;
            if ($urandom_range(0, 99) < 85) begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                hi = pool_high[pick];
                lo = pool_low[pick];
            end else begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            // time mostly creeps forward, sometimes jumps or goes anywhere
            pick = $urandom_range(0, 99);
            if (pick < 80)      clock_secs += 40'($urandom_range(0, 200));
            else if (pick < 95) clock_secs += 40'($urandom_range(0, 200000));
            now = (pick >= 98) ? 40'({$urandom, $urandom}) : clock_secs;
            pick = $urandom_range(0, 99);
            peers = (pick < 75) ? 16'($urandom) : (pick < 95) ? 16'($urandom_range(0, 600))
                                                             : 16'($urandom_range(0, 8));
            send_word(kind, hi, lo, now, peers);
        end
    endtask

    initial begin
        burst_left = 0;
        clock_secs = 40'd1000;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_high[i] = {$urandom, $urandom};
            pool_low[i]  = {$urandom, $urandom};
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings
        send_word(KIND_ADD,    '0, '0, 40'd0, 16'hFFFF);          // new entry
        send_word(KIND_ADD,    '0, '0, 40'd5, 16'hFFFF);          // reaches limit
        send_word(KIND_CHECK,  '0, '0, 40'd10, 16'd0);            // excluded
        send_word(KIND_CHECK,  '0, '0, 40'hFF_FFFF_FFFF, 16'd0);  // long expired: erased
        send_word(KIND_CHECK,  '0, '0, 40'd20, 16'd0);            // gone
        send_word(KIND_ADD,    '1, '1, 40'hFF_FFFF_FFFF, 16'hFFFF);
        send_word(KIND_ADD,    '1, '1, 40'hFF_FFFF_FFFF, 16'hFFFF);
        send_word(KIND_ADD,    '1, '1, 40'hFF_FFFF_FFFF, 16'hFFFF); // above limit
        send_word(KIND_CHECK,  '1, '1, 40'hFF_FFFF_FFFF, 16'hFFFF);
        send_word(KIND_REMOVE, '1, '1, 40'd0, 16'd0);
        send_word(KIND_REMOVE, '1, '1, 40'd0, 16'd0);             // absent
        send_word(KIND_NONE,   64'h1, 64'h2, 40'd3, 16'd4);
        send_word(KIND_CHECK,  64'h5, 64'h6, 40'd7, 16'd8);       // unknown
        send_word(KIND_ADD,    64'h10, 64'h0, 40'd100, 16'hFFFF);
        send_word(KIND_ADD,    64'h20, 64'h0, 40'd200, 16'hFFFF);
        send_word(KIND_ADD,    64'h10, 64'h0, 40'd300, 16'd0);    // evicts itself
        send_word(KIND_ADD,    64'h30, 64'h0, 40'd300, 16'd0);    // eviction down to one
        drain();

        // score saturation with limit 1 and short times
        write_regs(8'd1, 20'd1, 20'd1, 9'd256);
        for (int i = 0; i < 6; i++)
            send_word(KIND_ADD, 64'h77, 64'h88, 40'd400, 16'hFFFF);
        send_word(KIND_CHECK, 64'h77, 64'h88, 40'd401, 16'hFFFF);
        drain();
        write_regs(8'd2, 20'd1, 20'd1, 9'd256);
        for (int i = 0; i < 260; i++)
            send_word(KIND_ADD, 64'h99, 64'h0, 40'd500, 16'hFFFF);
        drain();

        // random phases across register settings
        random_words(270);
        drain();
        write_regs(8'd255, 20'hFFFFF, 20'hFFFFF, 9'd0);
        random_words(200);
        drain();
        write_regs(8'd3, 20'd50, 20'd20, 9'd300);
        random_words(270);
        drain();
        write_regs(8'd2, 20'd3600, 20'd86400, 9'd128);
        random_words(270);
        drain();
        write_regs(8'd1, 20'd2, 20'd1, 9'd511);
        random_words(100);
        drain();

        repeat (300) @(posedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
design/pbst_pkg.sv
design/pbst_cell.sv
design/peer_ban_score_table.sv
dv/peer_ban_checker.sv
dv/tb_peer_ban_score_table.sv
